### src/sha256_pkg.sv
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types and constants for the SHA-256 byte stream hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

  localparam int unsigned DigestWords = 8;
  localparam int unsigned BlockWords = 16;
  localparam int unsigned Rounds = 64;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_LEN,
    ST_EMIT
  } state_e;

  localparam logic [31:0] RoundConst [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] InitHash [DigestWords] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenStart = 6'd56;
  localparam logic [63:0] BlockBits = 64'd512;

  localparam logic FuncAbsorb = 1'b0;
  localparam logic FuncFinal = 1'b1;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

### src/sha256_if.sv
// ----------------------------------------------------------------------------
// sha256 channel interfaces
// Input and output channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sha256_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] data_byte;
  modport source (output valid, func, data_byte, input ready);
  modport sink (input valid, func, data_byte, output ready);
endinterface

interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

### src/sha256_round.sv
// ----------------------------------------------------------------------------
// sha256_round
// One compression round and one message schedule step, combinational.
// ----------------------------------------------------------------------------
module sha256_round (
  input  logic [255:0] vars_i,
  input  logic [31:0]  k_i,
  input  logic [31:0]  w_i,
  input  logic [511:0] sched_i,
  output logic [255:0] vars_o,
  output logic [511:0] sched_o
);
  import sha256_pkg::*;

  logic [31:0] a, b, c, d, e, f, g, h;
  logic [31:0] t1, t2, s0, s1, wn, x, y;

  // round function
  always_comb begin
    {a, b, c, d, e, f, g, h} = vars_i;
    t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g)) + k_i + w_i;
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
    vars_o = {t1 + t2, a, b, c, d + t1, e, f, g};
  end

  // schedule window, word 0 is w[t]
  always_comb begin
    x = sched_i[32*14 +: 32];
    y = sched_i[32*1 +: 32];
    s1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    s0 = rotr(y, 7) ^ rotr(y, 18) ^ (y >> 3);
    wn = s1 + sched_i[32*9 +: 32] + s0 + sched_i[31:0];
    sched_o = {wn, sched_i[511:32]};
  end

endmodule

### src/sha256_byte_stream_hasher.sv
// Absorb: each byte is written to the buffer as it is taken; a block-completing byte adds
//   16 buffer reads, 64 rounds and 8 chaining adds, bound by the one-round unit.
// Finalize: padding writes to the buffer, one or two compressions, then eight
//   digest words, one per cycle as the sink takes them.
// No byte is taken while a block is compressed or a digest is emitted.
// Reset is asynchronous, active low; restores initial hash, fill and bit count.
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher
// SHA-256 over a byte stream; block buffer and chaining value in memories.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher (
  input  logic clk_i,
  input  logic rst_ni,
  sha256_in_if.sink    in_i,
  sha256_out_if.source out_o
);
  import sha256_pkg::*;

  // block buffer, stored as 16 words of 4 bytes with byte enables
  logic [31:0] buf_mem [BlockWords];
  logic [31:0] buf_rd_q;
  logic        buf_we;
  logic [3:0]  buf_be;
  logic [3:0]  buf_waddr;
  logic [31:0] buf_wdata;
  logic [3:0]  buf_raddr;

  // chaining value memory, valid bits give the initial hash
  logic [31:0] cv_mem [DigestWords];
  logic [DigestWords-1:0] cv_ok_q, cv_ok_d;
  logic [31:0] cv_rd_q;
  logic        cv_rd_ok_q;
  logic        cv_we;
  logic [2:0]  cv_waddr, cv_raddr;
  logic [31:0] cv_wdata;
  logic [31:0] cv_rd;

  state_e      state_q, state_d;
  logic [5:0]  fill_q, fill_d;
  logic [63:0] bits_q, bits_d;
  logic [63:0] total_q, total_d;
  logic        fin_q, fin_d;
  logic        two_q, two_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [255:0] vars_q, vars_d, vars_n;
  logic [511:0] sched_q, sched_d, sched_n;
  logic [31:0]  k;
  logic [2:0]   widx;

  always_ff @(posedge clk_i) begin
    if (buf_we) begin
      for (int i = 0; i < 4; i++) begin
        if (buf_be[i]) buf_mem[buf_waddr][8*i +: 8] <= buf_wdata[8*i +: 8];
      end
    end
    buf_rd_q <= buf_mem[buf_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cv_we) cv_mem[cv_waddr] <= cv_wdata;
    cv_rd_q <= cv_mem[cv_raddr];
  end

  assign cv_rd = cv_rd_ok_q ? cv_rd_q : InitHash[widx];

  assign k = RoundConst[cnt_q[5:0]];

  sha256_round u_round (
    .vars_i  (vars_q),
    .k_i     (k),
    .w_i     (sched_q[31:0]),
    .sched_i (sched_q),
    .vars_o  (vars_n),
    .sched_o (sched_n)
  );

  // control
  always_comb begin
    logic [1:0] bsel;
    state_d = state_q;
    fill_d = fill_q;
    bits_d = bits_q;
    total_d = total_q;
    fin_d = fin_q;
    two_d = two_q;
    cnt_d = cnt_q;
    vars_d = vars_q;
    sched_d = sched_q;
    cv_ok_d = cv_ok_q;
    buf_we = 1'b0;
    buf_be = '0;
    buf_waddr = fill_q[5:2];
    buf_wdata = '0;
    buf_raddr = cnt_q[3:0];
    cv_we = 1'b0;
    cv_waddr = cnt_q[2:0];
    cv_wdata = '0;
    cv_raddr = cnt_q[2:0];
    widx = 3'd0;
    in_i.ready = 1'b0;
    out_o.valid = 1'b0;
    bsel = 2'd3 - fill_q[1:0];
    case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        cnt_d = '0;
        if (in_i.valid) begin
          buf_be[bsel] = 1'b1;
          if (in_i.func == FuncAbsorb) begin
            buf_we = 1'b1;
            buf_wdata = {4{in_i.data_byte}};
            fill_d = fill_q + 6'd1;
            fin_d = 1'b0;
            if (fill_q == 6'd63) state_d = ST_LOAD;
          end else begin
            buf_we = 1'b1;
            buf_wdata = {4{PadByte}};
            total_d = bits_q + {55'd0, fill_q, 3'd0};
            fin_d = 1'b1;
            two_d = (fill_q >= LenStart);
            fill_d = fill_q + 6'd1;
            // pad byte right before the length field needs no zero bytes
            if (fill_q == 6'd63) state_d = ST_LOAD;
            else if (fill_q == LenStart - 6'd1) state_d = ST_LEN;
            else state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        // zero bytes up to the length field, or to the block end when the length needs a second block
        buf_we = 1'b1;
        buf_be[bsel] = 1'b1;
        fill_d = fill_q + 6'd1;
        if (!two_q && fill_q == LenStart - 6'd1) state_d = ST_LEN;
        if (two_q && fill_q == 6'd63) state_d = ST_LOAD;
      end
      ST_LEN: begin
        buf_we = 1'b1;
        buf_be = 4'hf;
        buf_waddr = {3'b111, cnt_q[0]};
        buf_wdata = cnt_q[0] ? total_q[31:0] : total_q[63:32];
        cnt_d = cnt_q + 7'd1;
        if (cnt_q[0]) begin
          cnt_d = '0;
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        // stream 16 words into the schedule window, read cv alongside
        cnt_d = cnt_q + 7'd1;
        widx = cnt_q[2:0] - 3'd1;
        if (cnt_q != 7'd0) begin
          sched_d = {buf_rd_q, sched_q[511:32]};
          if (cnt_q <= 7'd8) vars_d = {vars_q[223:0], cv_rd};
        end
        if (cnt_q == 7'd16) begin
          cnt_d = '0;
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        vars_d = vars_n;
        sched_d = sched_n;
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd63) begin
          cnt_d = '0;
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        // read cv word then write cv + var
        cnt_d = cnt_q + 7'd1;
        widx = cnt_q[2:0] - 3'd1;
        if (cnt_q != 7'd0) begin
          cv_we = 1'b1;
          cv_waddr = widx;
          cv_wdata = cv_rd + vars_q[255 - 32*widx -: 32];
          cv_ok_d[widx] = 1'b1;
        end
        if (cnt_q == 7'd8) begin
          cnt_d = '0;
          if (!fin_q) begin
            bits_d = bits_q + BlockBits;
            state_d = ST_IDLE;
          end else if (two_q) begin
            two_d = 1'b0;
            fill_d = '0;
            state_d = ST_PAD;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        // cv_raddr=cnt gives word cnt next cycle; word shown once cnt>0
        widx = cnt_q[2:0] - 3'd1;
        if (cnt_q == 7'd0) begin
          cnt_d = 7'd1;
        end else begin
          out_o.valid = 1'b1;
          cv_raddr = out_o.ready ? cnt_q[2:0] : widx;
          if (out_o.ready) begin
            cnt_d = cnt_q + 7'd1;
            if (cnt_q == 7'd8) begin
              cnt_d = '0;
              cv_ok_d = '0;
              fill_d = '0;
              bits_d = '0;
              fin_d = 1'b0;
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
    out_o.digest_word = cv_rd;
    out_o.word_index = widx;
    out_o.last_word = (widx == 3'd7);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q <= '0;
      bits_q <= '0;
      fin_q <= 1'b0;
      two_q <= 1'b0;
      cnt_q <= '0;
      cv_ok_q <= '0;
      cv_rd_ok_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q <= fill_d;
      bits_q <= bits_d;
      fin_q <= fin_d;
      two_q <= two_d;
      cnt_q <= cnt_d;
      cv_ok_q <= cv_ok_d;
      cv_rd_ok_q <= cv_ok_q[cv_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    total_q <= total_d;
    vars_q <= vars_d;
    sched_q <= sched_d;
  end

endmodule

### src/sha256_checker.sv
// ----------------------------------------------------------------------------
// sha256_checker
// Port-level checks on the hasher channels.
// ----------------------------------------------------------------------------
module sha256_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] digest_word,
  input logic [2:0]  word_index,
  input logic        last_word
);

  // no input taken while a digest is being shown
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_valid && in_ready)) else $error("input ready during digest output");

  // last flag matches the final index
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (last_word == (word_index == 3'd7))) else $error("bad last flag");

  // word index steps by one after each taken word
  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_ready && !last_word) |=> (out_valid &&
      word_index == $past(word_index) + 3'd1)) else $error("word index skipped");

  // stalled word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> (out_valid && $stable(digest_word)))
    else $error("stalled word changed");

endmodule

bind sha256_byte_stream_hasher sha256_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid    (in_i.valid),
  .in_ready    (in_i.ready),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .digest_word (out_o.digest_word),
  .word_index  (out_o.word_index),
  .last_word   (out_o.last_word)
);
